### rtl/acwp_pkg.sv
// ============================================================================
// acwp_pkg
// Shared types and constants for the aspect crop window placer.
// ============================================================================
package acwp_pkg;

    // Configuration port index width (four registers)
    localparam int CFG_IDX_W = 2;

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_RATIO_WIDTH  = 2'd2,
        CFG_RATIO_HEIGHT = 2'd3
    } cfg_idx_t;

    // Candidate lower corners tried on each axis, in evaluation order
    typedef enum logic [1:0] {
        CAND_ZERO   = 2'd0,
        CAND_CENTER = 2'd1,
        CAND_BELOW  = 2'd2,
        CAND_FAR    = 2'd3
    } cand_t;

endpackage

### rtl/acwp_req_if.sv
// ============================================================================
// acwp_req_if
// Request channel: focus point beat with valid/ready handshake.
// ============================================================================
interface acwp_req_if #(
    parameter int W = 16
);
    logic         valid;
    logic         ready;
    logic [W-1:0] focus_x;
    logic [W-1:0] focus_y;

    modport source (output valid, output focus_x, output focus_y, input ready);
    modport sink   (input valid, input focus_x, input focus_y, output ready);
endinterface

### rtl/acwp_rsp_if.sv
// ============================================================================
// acwp_rsp_if
// Response channel: window corners and no-fit flag with valid/ready handshake.
// ============================================================================
interface acwp_rsp_if #(
    parameter int W = 16
);
    logic         valid;
    logic         ready;
    logic [W-1:0] left_x;
    logic [W-1:0] bottom_y;
    logic [W-1:0] right_x;
    logic [W-1:0] top_y;
    logic         no_fit;

    modport source (
        output valid, output left_x, output bottom_y, output right_x,
        output top_y, output no_fit, input ready
    );
    modport sink (
        input valid, input left_x, input bottom_y, input right_x,
        input top_y, input no_fit, output ready
    );
endinterface

### rtl/acwp_div.sv
// ============================================================================
// acwp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module acwp_div
    import acwp_pkg::*;
#(
    parameter int W = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic         done,
    output logic [W-1:0] quo
);
    localparam int CNT_W = $clog2(W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     den_reg;

    logic [W:0] shifted;
    logic [W:0] den_ext;
    logic [W:0] diff;
    logic       fits;

    // trial subtract of the divisor from the partial remainder
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign den_ext = {1'b0, den_reg};
    assign fits    = (shifted >= den_ext);
    assign diff    = shifted - den_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W);
                rem_reg  <= '0;
                quo_reg  <= num;
                den_reg  <= den;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? diff[W-1:0] : shifted[W-1:0];
                quo_reg <= {quo_reg[W-2:0], fits};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

### rtl/acwp_pick.sv
// ============================================================================
// acwp_pick
// Axis placement unit: walks the four candidate lower corners of one axis,
// one per cycle, and keeps the valid one nearest the focus (ties: smaller).
// ============================================================================
module acwp_pick
    import acwp_pkg::*;
#(
    parameter int W = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] extent,
    input  logic [W-1:0] size,
    input  logic [W-1:0] focus,
    output logic         done,
    output logic [W-1:0] pos
);
    localparam int CW = W + 4;
    localparam logic signed [CW-1:0] ONE_S = CW'(1);

    logic                 busy_reg;
    logic                 done_reg;
    logic                 have_reg;
    cand_t                idx_reg;
    logic signed [CW-1:0] best_d_reg;
    logic [W-1:0]         best_c_reg;

    logic signed [CW-1:0] e_s;
    logic signed [CW-1:0] s_s;
    logic signed [CW-1:0] f_s;
    logic signed [CW-1:0] half_s;
    logic signed [CW-1:0] cand;
    logic signed [CW-1:0] diff;
    logic signed [CW-1:0] gap;
    logic                 cand_ok;
    logic                 take;

    assign e_s    = $signed({4'b0, extent});
    assign s_s    = $signed({4'b0, size});
    assign f_s    = $signed({4'b0, focus});
    assign half_s = $signed({5'b0, size[W-1:1]});

    // candidate corner for the current step
    always_comb
    begin
        case (idx_reg)
            CAND_ZERO:   cand = '0;
            CAND_CENTER: cand = f_s - half_s;
            CAND_BELOW:  cand = f_s - half_s - ONE_S;
            CAND_FAR:    cand = e_s - s_s;
            default:     cand = '0;
        endcase
    end

    // in-frame check and doubled center distance
    assign cand_ok = !cand[CW-1] && ((cand + s_s) <= e_s);
    assign diff    = (f_s <<< 1) - (cand <<< 1) - s_s;
    assign gap     = diff[CW-1] ? -diff : diff;
    assign take    = busy_reg && cand_ok &&
                     (!have_reg || (gap < best_d_reg) ||
                      ((gap == best_d_reg) && (cand[W-1:0] < best_c_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            have_reg   <= 1'b0;
            idx_reg    <= CAND_ZERO;
            best_d_reg <= '0;
            best_c_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                have_reg <= 1'b0;
                idx_reg  <= CAND_ZERO;
            end
            else if (busy_reg)
            begin
                if (take)
                begin
                    have_reg   <= 1'b1;
                    best_d_reg <= gap;
                    best_c_reg <= cand[W-1:0];
                end
                if (idx_reg == CAND_FAR)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    idx_reg <= cand_t'(idx_reg + 2'd1);
                end
            end
        end
    end

    assign done = done_reg;
    assign pos  = best_c_reg;

endmodule

### rtl/aspect_crop_window_placer_core.sv
// ============================================================================
// aspect_crop_window_placer_core
// Places the largest window of the configured aspect ratio inside the frame,
// centered as near the requested focus point as the frame edges allow.
// ============================================================================
// One request is worked at a time; the request channel is ready only while
// the sequencer is idle. The binary gcd of the ratio terms runs first, then
// the shared bit-serial divider runs four divides (ratio reduction and the
// two scale quotients), followed by two multiplies, two axis placement
// passes and the output load, which waits for the output register to drain.
// A zero ratio term goes straight from the request beat to the output load
// with no_fit set; a ratio that does not fit the frame skips the multiplies
// and placement. The finished result sits in an output register, so the
// next request is taken while it waits to be drained. Configuration
// registers reset to 1 and must be written only while the block is idle.
// ============================================================================
module aspect_crop_window_placer_core
    import acwp_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COORD_BITS-1:0] cfg_data,
    acwp_req_if.sink              req,
    acwp_rsp_if.source            rsp
);
    localparam int W     = COORD_BITS;
    localparam int SFT_W = $clog2(W + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_GCD,
        S_DIV_RA,
        S_DIV_RB,
        S_DIV_KY,
        S_DIV_KX,
        S_MUL_X,
        S_MUL_Y,
        S_PICK_X,
        S_PICK_Y,
        S_DONE
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [W-1:0] frame_w_reg;
    logic [W-1:0] frame_h_reg;
    logic [W-1:0] ratio_w_reg;
    logic [W-1:0] ratio_h_reg;

    // working registers
    logic [W-1:0]     fx_reg;
    logic [W-1:0]     fy_reg;
    logic [W-1:0]     u_reg;
    logic [W-1:0]     v_reg;
    logic [SFT_W-1:0] shift_reg;
    logic [W-1:0]     g_reg;
    logic [W-1:0]     ra_reg;
    logic [W-1:0]     rb_reg;
    logic [W-1:0]     ky_reg;
    logic [W-1:0]     k_reg;
    logic [W-1:0]     dx_reg;
    logic [W-1:0]     dy_reg;
    logic [W-1:0]     p_reg;
    logic             nofit_reg;

    // shared unit launch
    logic         div_go_reg;
    logic [W-1:0] div_num_reg;
    logic [W-1:0] div_den_reg;
    logic         pick_go_reg;
    logic [W-1:0] pick_e_reg;
    logic [W-1:0] pick_s_reg;
    logic [W-1:0] pick_f_reg;

    // output register
    logic         rsp_valid_reg;
    logic [W-1:0] left_reg;
    logic [W-1:0] bottom_reg;
    logic [W-1:0] right_reg;
    logic [W-1:0] top_reg;
    logic         rsp_nofit_reg;

    logic         div_done;
    logic [W-1:0] div_quo;
    logic         pick_done;
    logic [W-1:0] pick_pos;
    logic [W-1:0] k_min;
    logic [W-1:0] mul_a;
    logic [2*W-1:0] prod;
    logic [W-1:0] gcd_val;
    logic         out_free;

    // ------------------------------------------------------------------
    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_w_reg <= W'(1);
            frame_h_reg <= W'(1);
            ratio_w_reg <= W'(1);
            ratio_h_reg <= W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_FRAME_WIDTH:  frame_w_reg <= cfg_data;
                CFG_FRAME_HEIGHT: frame_h_reg <= cfg_data;
                CFG_RATIO_WIDTH:  ratio_w_reg <= cfg_data;
                CFG_RATIO_HEIGHT: ratio_h_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Shared units
    acwp_div #(.W(W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_go_reg),
        .num   (div_num_reg),
        .den   (div_den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    acwp_pick #(.W(W)) u_pick (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (pick_go_reg),
        .extent (pick_e_reg),
        .size   (pick_s_reg),
        .focus  (pick_f_reg),
        .done   (pick_done),
        .pos    (pick_pos)
    );

    // window size multiplier, shared by both axes
    assign mul_a = (state_reg == S_MUL_X) ? ra_reg : rb_reg;
    assign prod  = {{W{1'b0}}, mul_a} * {{W{1'b0}}, k_reg};

    assign k_min    = (ky_reg < div_quo) ? ky_reg : div_quo;
    assign gcd_val  = u_reg << shift_reg;
    assign out_free = !rsp_valid_reg || rsp.ready;

    // ------------------------------------------------------------------
    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_go_reg    <= 1'b0;
            pick_go_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
            fx_reg        <= '0;
            fy_reg        <= '0;
            u_reg         <= '0;
            v_reg         <= '0;
            shift_reg     <= '0;
            g_reg         <= '0;
            ra_reg        <= '0;
            rb_reg        <= '0;
            ky_reg        <= '0;
            k_reg         <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            p_reg         <= '0;
            nofit_reg     <= 1'b0;
            div_num_reg   <= '0;
            div_den_reg   <= '0;
            pick_e_reg    <= '0;
            pick_s_reg    <= '0;
            pick_f_reg    <= '0;
            left_reg      <= '0;
            bottom_reg    <= '0;
            right_reg     <= '0;
            top_reg       <= '0;
            rsp_nofit_reg <= 1'b0;
        end
        else
        begin
            div_go_reg  <= 1'b0;
            pick_go_reg <= 1'b0;
            // drained beat; S_DONE reloads the register itself
            if (rsp_valid_reg && rsp.ready && (state_reg != S_DONE))
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        fx_reg    <= req.focus_x;
                        fy_reg    <= req.focus_y;
                        u_reg     <= ratio_w_reg;
                        v_reg     <= ratio_h_reg;
                        shift_reg <= '0;
                        if ((ratio_w_reg == '0) || (ratio_h_reg == '0))
                        begin
                            nofit_reg <= 1'b1;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_GCD;
                        end
                    end
                end

                // binary gcd: one shift or halved subtract per cycle
                S_GCD:
                begin
                    if (u_reg == v_reg)
                    begin
                        g_reg       <= gcd_val;
                        div_num_reg <= ratio_w_reg;
                        div_den_reg <= gcd_val;
                        div_go_reg  <= 1'b1;
                        state_reg   <= S_DIV_RA;
                    end
                    else if (!u_reg[0] && !v_reg[0])
                    begin
                        u_reg     <= u_reg >> 1;
                        v_reg     <= v_reg >> 1;
                        shift_reg <= shift_reg + SFT_W'(1);
                    end
                    else if (!u_reg[0])
                    begin
                        u_reg <= u_reg >> 1;
                    end
                    else if (!v_reg[0])
                    begin
                        v_reg <= v_reg >> 1;
                    end
                    else if (u_reg > v_reg)
                    begin
                        u_reg <= (u_reg - v_reg) >> 1;
                    end
                    else
                    begin
                        v_reg <= (v_reg - u_reg) >> 1;
                    end
                end

                // reduced ratio terms, then the two scale quotients
                S_DIV_RA:
                begin
                    if (div_done)
                    begin
                        ra_reg      <= div_quo;
                        div_num_reg <= ratio_h_reg;
                        div_den_reg <= g_reg;
                        div_go_reg  <= 1'b1;
                        state_reg   <= S_DIV_RB;
                    end
                end

                S_DIV_RB:
                begin
                    if (div_done)
                    begin
                        rb_reg      <= div_quo;
                        div_num_reg <= frame_h_reg;
                        div_den_reg <= div_quo;
                        div_go_reg  <= 1'b1;
                        state_reg   <= S_DIV_KY;
                    end
                end

                S_DIV_KY:
                begin
                    if (div_done)
                    begin
                        ky_reg      <= div_quo;
                        div_num_reg <= frame_w_reg;
                        div_den_reg <= ra_reg;
                        div_go_reg  <= 1'b1;
                        state_reg   <= S_DIV_KX;
                    end
                end

                S_DIV_KX:
                begin
                    if (div_done)
                    begin
                        k_reg <= k_min;
                        if (k_min == '0)
                        begin
                            nofit_reg <= 1'b1;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_MUL_X;
                        end
                    end
                end

                // window size; fits the frame so the low half is exact
                S_MUL_X:
                begin
                    dx_reg    <= prod[W-1:0];
                    state_reg <= S_MUL_Y;
                end

                S_MUL_Y:
                begin
                    dy_reg      <= prod[W-1:0];
                    pick_e_reg  <= frame_w_reg;
                    pick_s_reg  <= dx_reg;
                    pick_f_reg  <= fx_reg;
                    pick_go_reg <= 1'b1;
                    state_reg   <= S_PICK_X;
                end

                // axes are independent: best x, then best y
                S_PICK_X:
                begin
                    if (pick_done)
                    begin
                        p_reg       <= pick_pos;
                        pick_e_reg  <= frame_h_reg;
                        pick_s_reg  <= dy_reg;
                        pick_f_reg  <= fy_reg;
                        pick_go_reg <= 1'b1;
                        state_reg   <= S_PICK_Y;
                    end
                end

                S_PICK_Y:
                begin
                    if (pick_done)
                    begin
                        nofit_reg <= 1'b0;
                        state_reg <= S_DONE;
                    end
                end

                // load output register once the previous beat has drained
                S_DONE:
                begin
                    if (out_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        rsp_nofit_reg <= nofit_reg;
                        if (nofit_reg)
                        begin
                            left_reg   <= '0;
                            bottom_reg <= '0;
                            right_reg  <= '0;
                            top_reg    <= '0;
                        end
                        else
                        begin
                            left_reg   <= p_reg;
                            bottom_reg <= pick_pos;
                            right_reg  <= p_reg + dx_reg;
                            top_reg    <= pick_pos + dy_reg;
                        end
                        nofit_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Channel drive
    assign req.ready    = (state_reg == S_IDLE);
    assign rsp.valid    = rsp_valid_reg;
    assign rsp.left_x   = left_reg;
    assign rsp.bottom_y = bottom_reg;
    assign rsp.right_x  = right_reg;
    assign rsp.top_y    = top_reg;
    assign rsp.no_fit   = rsp_nofit_reg;

endmodule
